/* rtl/dpc_pkg.sv */
// Shared widths, register indexes and reset values for the depth-to-point-cloud block.
package dpc_pkg;

	localparam int W_DEPTH = 16;
	localparam int W_COL   = 10;
	localparam int W_ROW   = 9;
	localparam int W_PITCH = 16;
	localparam int W_FOCAL = 24;
	localparam int W_XY    = 25;
	localparam int W_Z     = 24;
	localparam int W_DATA  = 24;

	localparam int W_SCALE = W_DEPTH + 8;
	localparam int W_U     = W_COL + W_PITCH;
	localparam int W_V     = W_ROW + W_PITCH;
	localparam int W_SUM   = 54;
	localparam int W_ROOT  = W_SUM / 2;
	localparam int W_PROD  = W_SCALE + W_U;
	localparam int W_NUM   = W_PROD + 2;
	localparam int W_DEN   = W_ROOT + 1;
	localparam int W_QUO   = 27;

	typedef enum logic [1:0] {
		CFG_CENTER_COL   = 2'd0,
		CFG_CENTER_ROW   = 2'd1,
		CFG_PIXEL_PITCH  = 2'd2,
		CFG_FOCAL_LENGTH = 2'd3
	} cfg_idx_t;

	localparam logic [W_COL-1:0]   RST_CENTER_COL   = 10'd320;
	localparam logic [W_ROW-1:0]   RST_CENTER_ROW   = 9'd240;
	localparam logic [W_PITCH-1:0] RST_PIXEL_PITCH  = 16'd367;
	localparam logic [W_FOCAL-1:0] RST_FOCAL_LENGTH = 24'd141558;

endpackage

/* rtl/depth_to_point_cloud.sv */
// Top level: pinhole back-projection of depth pixels into 3-D points.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | sink      | in_valid / in_stall     | depth, pixel_col, pixel_row
//  out     | source    | out_valid / out_stall   | point_x, point_y, point_z
//  cfg     | sink      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One item per clock while no held result is stalled; four front stages, a nine-stage
//  square root, one numerator stage, a nine-stage divider and one output register.
//  The divider and square root pipelines resolve three bits per stage, which sets depth.
//  Reset clears all valid bits and loads the default optics registers.
//  A stalled output freezes every stage at once; nothing is dropped or repeated.
//  cfg_ready is always high; write registers only while the pipeline is empty.
module depth_to_point_cloud
	import dpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [W_DEPTH-1:0]  depth,
	input  logic [W_COL-1:0]    pixel_col,
	input  logic [W_ROW-1:0]    pixel_row,

	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [W_XY-1:0] point_x,
	output logic signed [W_XY-1:0] point_y,
	output logic [W_Z-1:0]      point_z,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cfg_idx_t            cfg_index,
	input  logic [W_DATA-1:0]   cfg_data
);

	localparam int STEP  = 3;
	localparam int SB_SQ = 2 + 3 * W_PROD;

	// Optics registers
	logic [W_COL-1:0]   center_col_q;
	logic [W_ROW-1:0]   center_row_q;
	logic [W_PITCH-1:0] pixel_pitch_q;
	logic [W_FOCAL-1:0] focal_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q   <= RST_CENTER_COL;
			center_row_q   <= RST_CENTER_ROW;
			pixel_pitch_q  <= RST_PIXEL_PITCH;
			focal_length_q <= RST_FOCAL_LENGTH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CENTER_COL:   center_col_q   <= cfg_data[W_COL-1:0];
				CFG_CENTER_ROW:   center_row_q   <= cfg_data[W_ROW-1:0];
				CFG_PIXEL_PITCH:  pixel_pitch_q  <= cfg_data[W_PITCH-1:0];
				CFG_FOCAL_LENGTH: focal_length_q <= cfg_data[W_FOCAL-1:0];
				default: ;
			endcase
		end
	end

	// Global advance: the whole pipeline moves unless a held result is blocked.
	logic out_valid_q;
	logic en;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// Stage 1: signed offsets from the optical center, split into magnitude and sign.
	logic [W_COL:0]     dcol;
	logic [W_ROW:0]     drow;
	logic               valid_s1;
	logic [W_COL-1:0]   cmag_s1;
	logic [W_ROW-1:0]   rmag_s1;
	logic               xneg_s1;
	logic               rneg_s1;
	logic [W_DEPTH-1:0] depth_s1;

	assign dcol = {1'b0, pixel_col} - {1'b0, center_col_q};
	assign drow = {1'b0, pixel_row} - {1'b0, center_row_q};

	// Stage 2: sensor offsets u and v.
	logic               valid_s2;
	logic [W_U-1:0]     u_s2;
	logic [W_V-1:0]     v_s2;
	logic               xneg_s2;
	logic               yneg_s2;
	logic [W_DEPTH-1:0] depth_s2;

	// Stage 3: squares for the distance and scaled numerator products.
	logic               valid_s3;
	logic [2*W_U-1:0]   uu_s3;
	logic [2*W_V-1:0]   vv_s3;
	logic [2*W_FOCAL-1:0] ff_s3;
	logic [W_PROD-1:0]  px_s3;
	logic [W_PROD-1:0]  py_s3;
	logic [W_PROD-1:0]  pz_s3;
	logic               xneg_s3;
	logic               yneg_s3;
	logic [W_SCALE-1:0] scale;

	assign scale = {depth_s2, 8'b0};

	// Stage 4: squared distance.
	logic               valid_s4;
	logic [W_SUM-1:0]   sum_s4;
	logic [SB_SQ-1:0]   sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmag_s1  <= dcol[W_COL] ? W_COL'(-dcol) : dcol[W_COL-1:0];
			rmag_s1  <= drow[W_ROW] ? W_ROW'(-drow) : drow[W_ROW-1:0];
			xneg_s1  <= dcol[W_COL];
			rneg_s1  <= drow[W_ROW];
			depth_s1 <= depth;

			u_s2     <= cmag_s1 * pixel_pitch_q;
			v_s2     <= rmag_s1 * pixel_pitch_q;
			xneg_s2  <= xneg_s1;
			// y points up: a row below center with nonzero offset goes negative
			yneg_s2  <= !rneg_s1 && (rmag_s1 != '0) && (pixel_pitch_q != '0);
			depth_s2 <= depth_s1;

			uu_s3    <= u_s2 * u_s2;
			vv_s3    <= v_s2 * v_s2;
			ff_s3    <= focal_length_q * focal_length_q;
			px_s3    <= scale * u_s2;
			py_s3    <= W_PROD'(scale * v_s2);
			pz_s3    <= W_PROD'(scale * focal_length_q);
			xneg_s3  <= xneg_s2;
			yneg_s3  <= yneg_s2;

			sum_s4   <= W_SUM'(uu_s3) + W_SUM'(vv_s3) + W_SUM'(ff_s3);
			sb_s4    <= {xneg_s3, yneg_s3, px_s3, py_s3, pz_s3};
		end
	end

	// Distance d = floor(sqrt(S)); products ride along as sideband.
	logic               sq_valid;
	logic [W_ROOT-1:0]  root;
	logic [SB_SQ-1:0]   sb_sq;

	dpc_isqrt #(
		.RW   (W_ROOT),
		.STEP (STEP),
		.SBW  (SB_SQ)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.radicand  (sum_s4),
		.sb_in     (sb_s4),
		.out_valid (sq_valid),
		.root      (root),
		.sb_out    (sb_sq)
	);

	// Stage 5: round-to-nearest numerators 2p + d over the shared divisor 2d.
	logic               valid_s5;
	logic [W_NUM-1:0]   nx_s5;
	logic [W_NUM-1:0]   ny_s5;
	logic [W_NUM-1:0]   nz_s5;
	logic [W_DEN-1:0]   den_s5;
	logic [2:0]         flags_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5    <= {1'b0, sb_sq[3*W_PROD-1:2*W_PROD], 1'b0} + W_NUM'(root);
			ny_s5    <= {1'b0, sb_sq[2*W_PROD-1:W_PROD], 1'b0} + W_NUM'(root);
			nz_s5    <= {1'b0, sb_sq[W_PROD-1:0], 1'b0} + W_NUM'(root);
			den_s5   <= {root, 1'b0};
			// zero distance forces a zero point
			flags_s5 <= {root == '0, sb_sq[SB_SQ-1], sb_sq[SB_SQ-2]};
		end
	end

	logic               dv_valid;
	logic [2:0]         flags_dv;
	logic [W_QUO-1:0]   qx;
	logic [W_QUO-1:0]   qy;
	logic [W_QUO-1:0]   qz;

	dpc_div #(
		.NW (W_NUM), .DW (W_DEN), .QW (W_QUO), .STEP (STEP), .SBW (3)
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.num       (nx_s5),
		.den       (den_s5),
		.sb_in     (flags_s5),
		.out_valid (dv_valid),
		.quo       (qx),
		.sb_out    (flags_dv)
	);

	dpc_div #(
		.NW (W_NUM), .DW (W_DEN), .QW (W_QUO), .STEP (STEP), .SBW (1)
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.num       (ny_s5),
		.den       (den_s5),
		.sb_in     (1'b0),
		.out_valid (),
		.quo       (qy),
		.sb_out    ()
	);

	dpc_div #(
		.NW (W_NUM), .DW (W_DEN), .QW (W_QUO), .STEP (STEP), .SBW (1)
	) u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.num       (nz_s5),
		.den       (den_s5),
		.sb_in     (1'b0),
		.out_valid (),
		.quo       (qz),
		.sb_out    ()
	);

	// Output register: apply zero-distance override and signs.
	logic [W_XY-1:0] mx;
	logic [W_XY-1:0] my;
	logic [W_XY-1:0] point_x_q;
	logic [W_XY-1:0] point_y_q;
	logic [W_Z-1:0]  point_z_q;

	assign mx = flags_dv[2] ? '0 : qx[W_XY-1:0];
	assign my = flags_dv[2] ? '0 : qy[W_XY-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			point_x_q <= flags_dv[1] ? W_XY'(-mx) : mx;
			point_y_q <= flags_dv[0] ? W_XY'(-my) : my;
			point_z_q <= flags_dv[2] ? '0 : qz[W_Z-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign point_x   = point_x_q;
	assign point_y   = point_y_q;
	assign point_z   = point_z_q;

	// A blocked input only ever comes from a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without a held result");

	// Frozen pipeline keeps its first-stage item.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !en) |=> valid_s1)
		else $error("stage 1 item lost during stall");

	// Quotients never exceed the depth scale, so the top bits stay clear;
	// a zero distance divides by zero and its quotients are dropped.
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_valid && !flags_dv[2]) |-> (qx[W_QUO-1:W_XY] == '0
			&& qy[W_QUO-1:W_XY] == '0 && qz[W_QUO-1:W_Z] == '0))
		else $error("divider quotient out of range");

endmodule

/* rtl/dpc_isqrt.sv */
// Pipelined integer square root, STEP root bits resolved per stage.
module dpc_isqrt #(
	parameter int RW   = 27,
	parameter int STEP = 3,
	parameter int SBW  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*RW-1:0]   radicand,
	input  logic [SBW-1:0]    sb_in,
	output logic              out_valid,
	output logic [RW-1:0]     root,
	output logic [SBW-1:0]    sb_out
);

	localparam int NST = RW / STEP;
	localparam int SW  = 2 * RW;
	localparam int RMW = RW + 2;

	logic           vld [NST+1];
	logic [RMW-1:0] rem [NST+1];
	logic [RW-1:0]  qr  [NST+1];
	logic [SW-1:0]  src [NST+1];
	logic [SBW-1:0] sb  [NST+1];

	assign vld[0] = in_valid;
	assign rem[0] = '0;
	assign qr[0]  = '0;
	assign src[0] = radicand;
	assign sb[0]  = sb_in;

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic [RMW-1:0] rem_n;
		logic [RW-1:0]  qr_n;
		logic [SW-1:0]  src_n;

		always_comb begin
			logic [RMW-1:0] t;
			logic [RMW-1:0] trial;
			rem_n = rem[k];
			qr_n  = qr[k];
			src_n = src[k];
			for (int i = 0; i < STEP; i++) begin
				t     = {rem_n[RMW-3:0], src_n[SW-1:SW-2]};
				trial = {qr_n, 2'b01};
				src_n = {src_n[SW-3:0], 2'b00};
				if (t >= trial) begin
					rem_n = t - trial;
					qr_n  = {qr_n[RW-2:0], 1'b1};
				end else begin
					rem_n = t;
					qr_n  = {qr_n[RW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[k+1] <= rem_n;
				qr[k+1]  <= qr_n;
				src[k+1] <= src_n;
				sb[k+1]  <= sb[k];
			end
		end
	end

	assign out_valid = vld[NST];
	assign root      = qr[NST];
	assign sb_out    = sb[NST];

endmodule

/* rtl/dpc_div.sv */
// Pipelined restoring divider, STEP quotient bits per stage; quotient must fit QW bits.
module dpc_div #(
	parameter int NW   = 52,
	parameter int DW   = 28,
	parameter int QW   = 27,
	parameter int STEP = 3,
	parameter int SBW  = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [NW-1:0]   num,
	input  logic [DW-1:0]   den,
	input  logic [SBW-1:0]  sb_in,
	output logic            out_valid,
	output logic [QW-1:0]   quo,
	output logic [SBW-1:0]  sb_out
);

	localparam int NST = QW / STEP;
	localparam int HW  = NW - QW;

	logic           vld [NST+1];
	logic [DW-1:0]  rem [NST+1];
	logic [QW-1:0]  qt  [NST+1];
	logic [QW-1:0]  nlo [NST+1];
	logic [DW-1:0]  dv  [NST+1];
	logic [SBW-1:0] sb  [NST+1];

	assign vld[0] = in_valid;
	assign rem[0] = {{(DW-HW){1'b0}}, num[NW-1:QW]};
	assign qt[0]  = '0;
	assign nlo[0] = num[QW-1:0];
	assign dv[0]  = den;
	assign sb[0]  = sb_in;

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic [DW-1:0] rem_n;
		logic [QW-1:0] qt_n;
		logic [QW-1:0] nlo_n;

		always_comb begin
			logic [DW:0] t;
			rem_n = rem[k];
			qt_n  = qt[k];
			nlo_n = nlo[k];
			for (int i = 0; i < STEP; i++) begin
				t     = {rem_n, nlo_n[QW-1]};
				nlo_n = {nlo_n[QW-2:0], 1'b0};
				if (t >= {1'b0, dv[k]}) begin
					t    = t - {1'b0, dv[k]};
					qt_n = {qt_n[QW-2:0], 1'b1};
				end else begin
					qt_n = {qt_n[QW-2:0], 1'b0};
				end
				rem_n = t[DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[k+1] <= rem_n;
				qt[k+1]  <= qt_n;
				nlo[k+1] <= nlo_n;
				dv[k+1]  <= dv[k];
				sb[k+1]  <= sb[k];
			end
		end
	end

	assign out_valid = vld[NST];
	assign quo       = qt[NST];
	assign sb_out    = sb[NST];

endmodule
